>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Each macro expands to one labeled concurrent assertion with reset gating.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, gated off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/sfr_pkg.sv
// Package for the serial frame receiver: frame constants, codes and result layout.
// No dependencies; used by serial_frame_receiver and sfr_checker.
`timescale 1ns / 1ps

package sfr_pkg;

    // Frame format
    localparam int          MAX_LEN      = 8;
    localparam int          SLOTS        = 8;
    localparam int          SLOT_IDX_W   = 3;
    localparam logic [7:0]  START_BYTE   = 8'h54;   // 'T'
    localparam logic [15:0] CFG_ID_LIMIT = 16'h07FF;
    localparam logic [7:0]  EMPTY_SLOT   = 8'hFF;
    localparam logic [15:0] IDLE_ID      = 16'h0FFF;
    localparam logic [3:0]  LEN_SAT      = 4'd15;

    // Result tdata layout, lowest bit up
    localparam int STATUS_LSB = 0;
    localparam int ID_LSB     = 2;
    localparam int LEN_LSB    = 18;
    localparam int DATA_LSB   = 22;
    localparam int OUT_W      = 88;

    // Status codes
    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_SUM = 2'd1,
        ST_CFG_ID  = 2'd2,
        ST_BAD_LEN = 2'd3
    } t_status;

    // Receive phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_ID_HI = 6'b000010,
        PH_ID_LO = 6'b000100,
        PH_LEN   = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_SUM   = 6'b100000
    } t_phase;

endpackage

>>> rtl/serial_frame_receiver.sv
// Serial frame receiver top level: rebuilds 'T' frames from a byte stream.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

//  Channel   Dir  Handshake                 Content
//  s_axis    in   tvalid/tready             tdata[7:0] = rx_byte
//  m_axis    out  tvalid/tready             tdata = status, frame_id, length, byte0..7
//  cfg       in   i_cfg_wen                 i_cfg_wdata = check_enable
//
//  One byte is taken per cycle; a frame result appears on m_axis the cycle after
//  its last byte (checksum, or a bad length byte) is accepted.
//  The output register acts as the skid: input is stalled only while a result
//  is held and m_axis tready is low.
//  Reset (i_rst_n low, synchronous) returns to waiting for 'T', check_enable = 1.

module serial_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wen,
    input  logic        i_cfg_wdata,        // check_enable
    // received bytes
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,     // [7:0] rx_byte
    // frame status results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata      // [1:0] status, [17:2] frame_id,
                                            // [21:18] length, [29:22] byte0 ..
                                            // [85:78] byte7, [87:86] zero
);

    // Frame state
    sfr_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_id, n_id;
    logic [3:0]      r_len, n_len;
    logic [7:0]      r_data [sfr_pkg::SLOTS];
    logic [7:0]      n_data [sfr_pkg::SLOTS];
    logic [3:0]      r_idx, n_idx;
    logic [7:0]      r_sum, n_sum;
    logic            r_check_en;

    // Result register
    logic            r_out_valid;
    logic [1:0]      r_out_status;
    logic [15:0]     r_out_id;
    logic [3:0]      r_out_len;
    logic [7:0]      r_out_data [sfr_pkg::SLOTS];

    logic            w_accept;
    logic            w_emit;
    logic [1:0]      w_status;
    logic [3:0]      w_idx_inc;
    logic [7:0]      w_b;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_b             = i_s_axis_tdata;
    assign w_idx_inc       = r_idx + 4'd1;

    // Per-byte next state and result
    always_comb begin
        n_phase  = r_phase;
        n_id     = r_id;
        n_len    = r_len;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_data   = r_data;
        w_emit   = 1'b0;
        w_status = sfr_pkg::ST_GOOD;
        unique case (r_phase)
            sfr_pkg::PH_ID_HI: begin
                n_id    = {w_b, 8'h00};
                n_phase = sfr_pkg::PH_ID_LO;
            end
            sfr_pkg::PH_ID_LO: begin
                n_id    = {r_id[15:8], w_b};
                n_sum   = w_b;
                n_phase = sfr_pkg::PH_LEN;
            end
            sfr_pkg::PH_LEN: begin
                n_len = (w_b > 8'(sfr_pkg::LEN_SAT)) ? sfr_pkg::LEN_SAT : w_b[3:0];
                if (w_b > 8'(sfr_pkg::MAX_LEN)) begin
                    w_emit   = 1'b1;
                    w_status = sfr_pkg::ST_BAD_LEN;
                    n_phase  = sfr_pkg::PH_IDLE;
                end else begin
                    n_sum   = r_sum + w_b;
                    n_idx   = 4'd0;
                    n_phase = (w_b != 8'd0) ? sfr_pkg::PH_DATA : sfr_pkg::PH_SUM;
                end
            end
            sfr_pkg::PH_DATA: begin
                n_data[r_idx[sfr_pkg::SLOT_IDX_W-1:0]] = w_b;
                n_sum = r_sum + w_b;
                n_idx = w_idx_inc;
                if (w_idx_inc >= r_len)
                    n_phase = sfr_pkg::PH_SUM;
            end
            sfr_pkg::PH_SUM: begin
                w_emit  = 1'b1;
                n_phase = sfr_pkg::PH_IDLE;
                if (r_check_en && (w_b != r_sum))
                    w_status = sfr_pkg::ST_BAD_SUM;
                else if (r_id > sfr_pkg::CFG_ID_LIMIT)
                    w_status = sfr_pkg::ST_CFG_ID;
                else
                    w_status = sfr_pkg::ST_GOOD;
            end
            default: begin
                // idle: every byte clears the frame, only 'T' starts one
                n_id  = sfr_pkg::IDLE_ID;
                n_len = sfr_pkg::LEN_SAT;
                n_idx = 4'd0;
                n_sum = 8'd0;
                for (int k = 0; k < sfr_pkg::SLOTS; k++)
                    n_data[k] = sfr_pkg::EMPTY_SLOT;
                n_phase = (w_b == sfr_pkg::START_BYTE) ? sfr_pkg::PH_ID_HI
                                                        : sfr_pkg::PH_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sfr_pkg::PH_IDLE;
            r_check_en  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen)
                r_check_en <= i_cfg_wdata;
            if (w_accept)
                r_phase <= n_phase;
            if (w_accept && w_emit)
                r_out_valid <= 1'b1;
            else if (i_m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    // Frame payload; idle clears it before use
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id   <= n_id;
            r_len  <= n_len;
            r_idx  <= n_idx;
            r_sum  <= n_sum;
            r_data <= n_data;
        end
    end

    // Result payload, loaded with the transaction that ends a frame
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out_status <= w_status;
            r_out_id     <= n_id;
            r_out_len    <= n_len;
            r_out_data   <= n_data;
        end
    end

    // Pack result
    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[sfr_pkg::STATUS_LSB +: 2] = r_out_status;
        o_m_axis_tdata[sfr_pkg::ID_LSB     +: 16] = r_out_id;
        o_m_axis_tdata[sfr_pkg::LEN_LSB    +: 4] = r_out_len;
        for (int k = 0; k < sfr_pkg::SLOTS; k++)
            o_m_axis_tdata[sfr_pkg::DATA_LSB + 8*k +: 8] = r_out_data[k];
    end

    assign o_m_axis_tvalid = r_out_valid;

endmodule

>>> rtl/sfr_checker.sv
// Port-level checks for serial_frame_receiver, attached by bind.
// Depends on sfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [87:0] o_m_axis_tdata
);

    logic       w_bad_len;
    logic [3:0] w_len;

    assign w_bad_len = o_m_axis_tdata[1:0] == sfr_pkg::ST_BAD_LEN;
    assign w_len     = o_m_axis_tdata[21:18];

    // A stalled result holds its transaction
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // Input stalls only behind a held, blocked result
    `ASSERT_IMPL(a_in_stall, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready)

    // Bad length status carries a length above the limit
    `ASSERT_IMPL(a_bad_len_len, i_clk, i_rst_n, o_m_axis_tvalid && w_bad_len, w_len > 4'(sfr_pkg::MAX_LEN))

    // Any other status carries a length within the limit
    `ASSERT_IMPL(a_ok_len, i_clk, i_rst_n, o_m_axis_tvalid && !w_bad_len, w_len <= 4'(sfr_pkg::MAX_LEN))

    // An aborted frame reports all data slots empty
    `ASSERT_IMPL(a_bad_len_data, i_clk, i_rst_n, o_m_axis_tvalid && w_bad_len, &o_m_axis_tdata[85:22])

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);
